/* hdl/modbus_rtu_read_holding_register_defines.svh */
// Assertion macros shared by the Modbus RTU read-holding-register block.
// Taken in by the modules that check their own logic; no other dependencies.
`ifndef MODBUS_RTU_READ_HOLDING_REGISTER_DEFINES_SVH
`define MODBUS_RTU_READ_HOLDING_REGISTER_DEFINES_SVH

// Property checked on the rising clock edge, ignored while reset is asserted.
`define MBRTU_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Property checked on every rising clock edge, reset included.
`define MBRTU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/mbrtu_pkg.sv */
// Shared types, codes and the CRC-16/MODBUS byte step for the Modbus RTU
// read-holding-register block. No dependencies.
`timescale 1ns / 1ps

package mbrtu_pkg;

    localparam logic [1:0] MODE_START = 2'd0;
    localparam logic [1:0] MODE_BYTE  = 2'd1;
    localparam logic [1:0] MODE_TICK  = 2'd2;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_TIMEOUT   = 2'd1;
    localparam logic [1:0] STAT_EXCEPTION = 2'd2;
    localparam logic [1:0] STAT_CRC_ERR   = 2'd3;

    localparam logic       KIND_TX   = 1'b0;
    localparam logic       KIND_DONE = 1'b1;

    localparam logic [15:0] CRC_INIT        = 16'hFFFF;
    localparam logic [15:0] CRC_POLY        = 16'hA001;
    localparam logic [7:0]  FC_READ_HOLDING = 8'h03;
    localparam logic [7:0]  QTY_HIGH        = 8'h00;
    localparam logic [7:0]  QTY_LOW         = 8'h01;
    localparam int          EXC_BIT_POS     = 7;
    localparam logic [15:0] TIMEOUT_RESET   = 16'd100;

    // Response bytes: address, function, count, value high, value low, crc low, crc high
    localparam logic [2:0] RSP_FUNC     = 3'd1;
    localparam logic [2:0] RSP_VAL_HIGH = 3'd3;
    localparam logic [2:0] RSP_VAL_LOW  = 3'd4;
    localparam logic [2:0] RSP_CRC_LOW  = 3'd5;
    localparam logic [2:0] RSP_CRC_HIGH = 3'd6;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // One job handed from the front to the back
    typedef struct packed {
        logic        is_start;
        logic [7:0]  slave;
        logic [15:0] reg_addr;
        logic [1:0]  status;
        logic [15:0] value;
    } cmd_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0] data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

/* hdl/mbrtu_front.sv */
// Front end: accepts input beats, tracks the transaction and the response
// bytes, and pushes start and completion jobs. Uses mbrtu_pkg.
`timescale 1ns / 1ps
`include "modbus_rtu_read_holding_register_defines.svh"

module mbrtu_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [15:0]       cfg_wdata,
    input  logic              accept_i,
    input  logic [1:0]        mode_i,
    input  logic [7:0]        slave_i,
    input  logic [15:0]       reg_addr_i,
    input  logic [7:0]        rx_i,
    input  logic              q_full_i,
    output logic              push_o,
    output mbrtu_pkg::cmd_t   push_cmd_o
);

    logic        busy_reg, busy_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [15:0] wait_reg, wait_next;
    logic [15:0] crc_reg, crc_next;
    logic [15:0] timeout_reg;
    logic [7:0]  fc_reg, hi_reg, lo_reg, crclo_reg;
    logic [15:0] crc_step;
    logic        store_fc, store_hi, store_lo, store_crclo;

    assign crc_step = mbrtu_pkg::crc_byte(crc_reg, rx_i);

    always_comb begin
        busy_next   = busy_reg;
        cnt_next    = cnt_reg;
        wait_next   = wait_reg;
        crc_next    = crc_reg;
        push_o      = 1'b0;
        push_cmd_o  = '0;
        store_fc    = 1'b0;
        store_hi    = 1'b0;
        store_lo    = 1'b0;
        store_crclo = 1'b0;
        if (accept_i) begin
            unique case (mode_i)
                mbrtu_pkg::MODE_START: begin
                    if (!busy_reg) begin
                        busy_next           = 1'b1;
                        cnt_next            = 3'd0;
                        wait_next           = timeout_reg;
                        crc_next            = mbrtu_pkg::CRC_INIT;
                        push_o              = 1'b1;
                        push_cmd_o.is_start = 1'b1;
                        push_cmd_o.slave    = slave_i;
                        push_cmd_o.reg_addr = reg_addr_i;
                    end
                end
                mbrtu_pkg::MODE_BYTE: begin
                    if (busy_reg) begin
                        wait_next = timeout_reg;
                        if (cnt_reg < mbrtu_pkg::RSP_CRC_LOW) begin
                            crc_next = crc_step;
                        end
                        store_fc    = (cnt_reg == mbrtu_pkg::RSP_FUNC);
                        store_hi    = (cnt_reg == mbrtu_pkg::RSP_VAL_HIGH);
                        store_lo    = (cnt_reg == mbrtu_pkg::RSP_VAL_LOW);
                        store_crclo = (cnt_reg == mbrtu_pkg::RSP_CRC_LOW);
                        if (cnt_reg != mbrtu_pkg::RSP_CRC_HIGH) begin
                            cnt_next = cnt_reg + 3'd1;
                        end else begin
                            busy_next = 1'b0;
                            cnt_next  = 3'd0;
                            push_o    = 1'b1;
                            // exception wins over a bad CRC
                            priority if (fc_reg[mbrtu_pkg::EXC_BIT_POS]) begin
                                push_cmd_o.status = mbrtu_pkg::STAT_EXCEPTION;
                            end else if (crc_reg != {rx_i, crclo_reg}) begin
                                push_cmd_o.status = mbrtu_pkg::STAT_CRC_ERR;
                            end else begin
                                push_cmd_o.status = mbrtu_pkg::STAT_OK;
                                push_cmd_o.value  = {hi_reg, lo_reg};
                            end
                        end
                    end
                end
                mbrtu_pkg::MODE_TICK: begin
                    if (busy_reg) begin
                        if (wait_reg <= 16'd1) begin
                            wait_next         = 16'd0;
                            busy_next         = 1'b0;
                            push_o            = 1'b1;
                            push_cmd_o.status = mbrtu_pkg::STAT_TIMEOUT;
                        end else begin
                            wait_next = wait_reg - 16'd1;
                        end
                    end
                end
                default: begin
                    // drop the beat
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            cnt_reg     <= 3'd0;
            wait_reg    <= 16'd0;
            crc_reg     <= mbrtu_pkg::CRC_INIT;
            timeout_reg <= mbrtu_pkg::TIMEOUT_RESET;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            wait_reg <= wait_next;
            crc_reg  <= crc_next;
            if (cfg_we) begin
                timeout_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (store_fc) begin
            fc_reg <= rx_i;
        end
        if (store_hi) begin
            hi_reg <= rx_i;
        end
        if (store_lo) begin
            lo_reg <= rx_i;
        end
        if (store_crclo) begin
            crclo_reg <= rx_i;
        end
    end

    `MBRTU_ASSERT(a_no_push_full, aclk, aresetn, !(push_o && q_full_i), "push into full queue")
    `MBRTU_ASSERT(a_cnt_range, aclk, aresetn, cnt_reg != 3'd7, "response byte count overran")
    `MBRTU_ASSERT(a_idle_cnt, aclk, aresetn, (push_o && !push_cmd_o.is_start) |=> !busy_reg, "busy after completion")

endmodule

/* hdl/mbrtu_queue.sv */
// Short job queue between the front and the back, held in flip-flops.
// Uses mbrtu_pkg for the job type and depth.
`timescale 1ns / 1ps
`include "modbus_rtu_read_holding_register_defines.svh"

module mbrtu_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push_i,
    input  mbrtu_pkg::cmd_t   push_cmd_i,
    input  logic              pop_i,
    output mbrtu_pkg::cmd_t   head_o,
    output logic              empty_o,
    output logic              full_o
);

    mbrtu_pkg::cmd_t                    mem_reg [mbrtu_pkg::QUEUE_DEPTH];
    logic [mbrtu_pkg::QUEUE_AW-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [mbrtu_pkg::QUEUE_AW:0]       count_reg, count_next;
    logic                               do_push, do_pop;

    assign empty_o = (count_reg == '0);
    assign full_o  = (count_reg == (mbrtu_pkg::QUEUE_AW + 1)'(mbrtu_pkg::QUEUE_DEPTH));
    assign head_o  = mem_reg[rd_ptr_reg];
    assign do_push = push_i && !full_o;
    assign do_pop  = pop_i && !empty_o;

    always_comb begin
        count_next = count_reg;
        unique case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_cmd_i;
        end
    end

    `MBRTU_ASSERT(a_count_max, aclk, aresetn, count_reg <= (mbrtu_pkg::QUEUE_AW + 1)'(mbrtu_pkg::QUEUE_DEPTH), "queue count overflow")
    `MBRTU_ASSERT(a_no_pop_empty, aclk, aresetn, !(pop_i && empty_o), "pop from empty queue")

endmodule

/* hdl/mbrtu_back.sv */
// Back end: takes jobs from the queue, sends the eight request bytes with
// their CRC, or reports a completion. Uses mbrtu_pkg.
`timescale 1ns / 1ps
`include "modbus_rtu_read_holding_register_defines.svh"

module mbrtu_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  mbrtu_pkg::cmd_t   head_i,
    input  logic              empty_i,
    output logic              pop_o,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic              m_tlast,
    output logic              m_kind,
    output logic [7:0]        m_tx_byte,
    output logic [1:0]        m_status,
    output logic [15:0]       m_reg_value
);

    typedef enum logic {
        ST_IDLE,
        ST_SEND
    } state_t;

    state_t      state_reg;
    logic [2:0]  idx_reg;
    logic [15:0] crc_reg;
    logic [15:0] reg_addr_reg;
    logic        slot_free;
    logic        load_beat;
    logic [7:0]  cur_byte;

    assign slot_free = !m_tvalid || m_tready;
    assign pop_o     = (state_reg == ST_IDLE) && !empty_i && slot_free;
    assign load_beat = pop_o || ((state_reg == ST_SEND) && slot_free);

    always_comb begin
        unique case (idx_reg)
            3'd0:    cur_byte = 8'h00;
            3'd1:    cur_byte = mbrtu_pkg::FC_READ_HOLDING;
            3'd2:    cur_byte = reg_addr_reg[15:8];
            3'd3:    cur_byte = reg_addr_reg[7:0];
            3'd4:    cur_byte = mbrtu_pkg::QTY_HIGH;
            3'd5:    cur_byte = mbrtu_pkg::QTY_LOW;
            3'd6:    cur_byte = crc_reg[7:0];
            default: cur_byte = crc_reg[15:8];
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg   <= 3'd0;
            m_tvalid  <= 1'b0;
        end else begin
            if (load_beat) begin
                m_tvalid <= 1'b1;
            end else if (m_tready) begin
                m_tvalid <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (pop_o) begin
                        m_tlast  <= 1'b0;
                        if (head_i.is_start) begin
                            // send the slave address now, the rest from SEND
                            m_kind       <= mbrtu_pkg::KIND_TX;
                            m_tx_byte    <= head_i.slave;
                            m_status     <= mbrtu_pkg::STAT_OK;
                            m_reg_value  <= 16'd0;
                            reg_addr_reg <= head_i.reg_addr;
                            crc_reg      <= mbrtu_pkg::crc_byte(mbrtu_pkg::CRC_INIT,
                                                                head_i.slave);
                            idx_reg      <= 3'd1;
                            state_reg    <= ST_SEND;
                        end else begin
                            m_kind      <= mbrtu_pkg::KIND_DONE;
                            m_tx_byte   <= 8'h00;
                            m_status    <= head_i.status;
                            m_reg_value <= head_i.value;
                        end
                    end
                end
                ST_SEND: begin
                    if (slot_free) begin
                        m_kind      <= mbrtu_pkg::KIND_TX;
                        m_tx_byte   <= cur_byte;
                        m_status    <= mbrtu_pkg::STAT_OK;
                        m_reg_value <= 16'd0;
                        m_tlast     <= (idx_reg == 3'd7);
                        if (idx_reg < 3'd6) begin
                            crc_reg <= mbrtu_pkg::crc_byte(crc_reg, cur_byte);
                        end
                        idx_reg <= idx_reg + 3'd1;
                        if (idx_reg == 3'd7) begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    `MBRTU_ASSERT(a_send_idx, aclk, aresetn, (state_reg == ST_SEND) |-> (idx_reg != 3'd0), "byte index lost in SEND")
    `MBRTU_ASSERT(a_last_is_tx, aclk, aresetn, (m_tvalid && m_tlast) |-> (m_kind == mbrtu_pkg::KIND_TX), "last flag on a completion")
    `MBRTU_ASSERT(a_no_pop_send, aclk, aresetn, (state_reg == ST_SEND) |-> !pop_o, "job taken while sending")

endmodule

/* hdl/modbus_rtu_read_holding_register.sv */
// Channel   Dir  tuser          tlast    tdata (low bit up)
// s_        in   mode[1:0]      -        slave_address, register_address, rx_byte
// m_        out  kind           last_tx  tx_byte, status, reg_value, 6 zero bits
// cfg_      in   -              -        timeout_ticks (write only)
//
// The front end handles each input beat as it is accepted; a start produces eight
// output beats, one per cycle while m_tready is high, from the back end's byte counter.
// A completion is one output beat; the four-entry job queue decouples the two.
// Reset is synchronous on aresetn, no clearing pass.
// m_tready low holds the output register; once the queue fills, s_tready drops.
// Top level of the Modbus RTU read-holding-register master.
// Depends on mbrtu_pkg, mbrtu_front, mbrtu_queue and mbrtu_back.
`timescale 1ns / 1ps

module modbus_rtu_read_holding_register (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,   // timeout_ticks
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,     // slave_address[7:0], register_address[23:8], rx_byte[31:24]
    input  logic [1:0]  s_tuser,     // mode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,     // tx_byte[7:0], status[9:8], reg_value[25:10], zero[31:26]
    output logic        m_tuser,     // kind
    output logic        m_tlast      // last_tx
);

    mbrtu_pkg::cmd_t push_cmd, head;
    logic            push, pop, q_empty, q_full;
    logic [7:0]      tx_byte;
    logic [1:0]      status;
    logic [15:0]     reg_value;

    assign s_tready = !q_full;
    assign m_tdata  = {6'd0, reg_value, status, tx_byte};

    mbrtu_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .accept_i   (s_tvalid && s_tready),
        .mode_i     (s_tuser),
        .slave_i    (s_tdata[7:0]),
        .reg_addr_i (s_tdata[23:8]),
        .rx_i       (s_tdata[31:24]),
        .q_full_i   (q_full),
        .push_o     (push),
        .push_cmd_o (push_cmd)
    );

    mbrtu_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_i     (push),
        .push_cmd_i (push_cmd),
        .pop_i      (pop),
        .head_o     (head),
        .empty_o    (q_empty),
        .full_o     (q_full)
    );

    mbrtu_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .head_i      (head),
        .empty_i     (q_empty),
        .pop_o       (pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tlast     (m_tlast),
        .m_kind      (m_tuser),
        .m_tx_byte   (tx_byte),
        .m_status    (status),
        .m_reg_value (reg_value)
    );

endmodule

/* tb/sv/modbus_rtu_read_holding_register_tb.sv */
// Self-checking stream testbench for the Modbus RTU read-holding-register master.
// Drives request, response-byte and tick beats, predicts every output beat in place.
// Depends on mbrtu_pkg and modbus_rtu_read_holding_register.
`timescale 1ns / 1ps

module modbus_rtu_read_holding_register_tb;
    import mbrtu_pkg::*;

    localparam logic [1:0] MODE_IGNORED = 2'd3;
    localparam int STALL_LIMIT  = 2000;
    localparam int LONG_HOLD    = 400;
    localparam int DRAIN_CYCLES = 24;
    localparam int PHASE_BEATS  = 66;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  slave;
        logic [15:0] regnum;
        logic [7:0]  rx;
    } beat_t;

    typedef struct packed {
        logic               kind;
        logic [7:0]         tx_byte;
        logic               last_tx;
        logic [1:0]         status;
        logic signed [15:0] reg_value;
    } reply_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [15:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;     // slave_address, register_address, rx_byte
    logic [1:0]  s_tuser = '0;     // mode
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;          // tx_byte, status, reg_value, zero pad
    logic        m_tuser;          // kind
    logic        m_tlast;          // last_tx

    modbus_rtu_read_holding_register dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Master state as predicted
    logic [15:0] tmo_ticks = TIMEOUT_RESET;
    logic        rsp_busy = 1'b0;
    logic [2:0]  rsp_count = '0;
    logic [15:0] ticks_left = '0;
    logic [15:0] rsp_crc = CRC_INIT;
    logic [7:0]  rsp_func, rsp_val_hi, rsp_val_lo, rsp_crc_lo;

    reply_t      replies_due[$];
    beat_t       feed[$];

    int unsigned n_queued = 0, n_frames = 0, n_ignored = 0;
    int unsigned outcome_seen [4] = '{0, 0, 0, 0};
    int unsigned n_errors = 0, n_results = 0, idle_cycles = 0;
    int unsigned s_offered = 0, s_taken = 0, s_gap = 0;
    int unsigned m_gap = 0, hold_left = 0;
    bit          calm = 1'b0, hold_req = 1'b0, hold_used = 1'b0;

    function automatic logic [15:0] crc16_step(logic [15:0] acc, logic [7:0] b);
        logic [15:0] r;
        r = acc ^ {8'h00, b};
        repeat (8) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        return r;
    endfunction

    task automatic push_reply(logic kind, logic [7:0] txb, logic last, logic [1:0] st,
                              logic [15:0] val);
        reply_t r;
        r.kind      = kind;
        r.tx_byte   = txb;
        r.last_tx   = last;
        r.status    = st;
        r.reg_value = val;
        replies_due.push_back(r);
    endtask

    task automatic finish_txn(logic [1:0] st, logic [15:0] val);
        rsp_busy = 1'b0;
        rsp_count = '0;
        outcome_seen[st]++;
        push_reply(KIND_DONE, 8'h00, 1'b0, st, val);
    endtask

    task automatic predict_beat(beat_t b);
        logic [7:0]  frame [8];
        logic [15:0] c;
        if (b.mode == MODE_START && !rsp_busy) begin
            frame[0] = b.slave;
            frame[1] = FC_READ_HOLDING;
            frame[2] = b.regnum[15:8];
            frame[3] = b.regnum[7:0];
            frame[4] = QTY_HIGH;
            frame[5] = QTY_LOW;
            c = CRC_INIT;
            for (int i = 0; i < 6; i++) c = crc16_step(c, frame[i]);
            frame[6] = c[7:0];
            frame[7] = c[15:8];
            for (int i = 0; i < 8; i++) push_reply(KIND_TX, frame[i], i == 7, STAT_OK, 16'd0);
            rsp_busy   = 1'b1;
            rsp_count  = '0;
            ticks_left = tmo_ticks;
            rsp_crc    = CRC_INIT;
            n_frames++;
        end else if (!rsp_busy || b.mode == MODE_START || b.mode == MODE_IGNORED) begin
            n_ignored++;
        end else if (b.mode == MODE_TICK) begin
            // a zero budget times out on the first tick, same as one
            if (ticks_left <= 16'd1) begin
                ticks_left = '0;
                finish_txn(STAT_TIMEOUT, 16'd0);
            end else begin
                ticks_left--;
            end
        end else begin
            ticks_left = tmo_ticks;
            if (rsp_count < RSP_CRC_LOW) rsp_crc = crc16_step(rsp_crc, b.rx);
            case (rsp_count)
                RSP_FUNC:     rsp_func   = b.rx;
                RSP_VAL_HIGH: rsp_val_hi = b.rx;
                RSP_VAL_LOW:  rsp_val_lo = b.rx;
                RSP_CRC_LOW:  rsp_crc_lo = b.rx;
                default: ;
            endcase
            if (rsp_count < RSP_CRC_HIGH) begin
                rsp_count++;
            end else if (rsp_func[EXC_BIT_POS]) begin
                finish_txn(STAT_EXCEPTION, 16'd0);
            end else if (rsp_crc != {b.rx, rsp_crc_lo}) begin
                finish_txn(STAT_CRC_ERR, 16'd0);
            end else begin
                finish_txn(STAT_OK, {rsp_val_hi, rsp_val_lo});
            end
        end
    endtask

    task automatic note_error(string msg);
        n_errors++;
        if (n_errors <= 10) $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    // Check results, update the prediction, and run the stall watchdog
    always @(posedge aclk) begin
        reply_t got, want;
        beat_t  in_beat;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got.kind      = m_tuser;
                got.tx_byte   = m_tdata[7:0];
                got.last_tx   = m_tlast;
                got.status    = m_tdata[9:8];
                got.reg_value = m_tdata[25:10];
                n_results++;
                if (replies_due.size() == 0) begin
                    note_error($sformatf("unexpected beat kind=%0d tx=%02h last=%0d st=%0d val=%0d",
                                         got.kind, got.tx_byte, got.last_tx, got.status,
                                         got.reg_value));
                end else begin
                    want = replies_due.pop_front();
                    if (got.kind != want.kind || got.tx_byte != want.tx_byte ||
                        got.last_tx != want.last_tx || got.status != want.status ||
                        got.reg_value != want.reg_value || m_tdata[31:26] != '0) begin
                        note_error($sformatf({"expected kind=%0d tx=%02h last=%0d st=%0d val=%0d,",
                                              " got kind=%0d tx=%02h last=%0d st=%0d val=%0d",
                                              " pad=%0h"},
                                             want.kind, want.tx_byte, want.last_tx, want.status,
                                             want.reg_value, got.kind, got.tx_byte, got.last_tx,
                                             got.status, got.reg_value, m_tdata[31:26]));
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                in_beat.mode   = s_tuser;
                in_beat.slave  = s_tdata[7:0];
                in_beat.regnum = s_tdata[23:8];
                in_beat.rx     = s_tdata[31:24];
                predict_beat(in_beat);
                s_taken <= s_taken + 1;
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles = 0;
            end else if (++idle_cycles == STALL_LIMIT) begin
                $display("watchdog: no beat moved for %0d cycles, %0d results still due",
                         STALL_LIMIT, replies_due.size());
                $display("modbus_rtu_read_holding_register regression: fail");
                $finish;
            end
        end
    end

    // Input driver: present the next pending beat once the current one is taken
    always @(negedge aclk) begin
        beat_t nb;
        if (aresetn && (!s_tvalid || s_taken == s_offered)) begin
            if (s_gap != 0 || feed.size() == 0) begin
                s_tvalid <= 1'b0;
                if (s_gap != 0) s_gap--;
            end else begin
                nb = feed.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= nb.mode;
                s_tdata  <= {nb.rx, nb.regnum, nb.slave};
                s_offered++;
                if (!calm && $urandom_range(0, 7) == 0) s_gap = $urandom_range(1, 13);
            end
        end
    end

    // Output backpressure, with one long hold on request
    always @(negedge aclk) begin
        if (aresetn) begin
            if (hold_req && !hold_used) begin
                hold_used = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (m_gap != 0) begin
                m_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (!calm && $urandom_range(0, 9) == 0) m_gap = $urandom_range(1, 13);
            end
        end
    end

    task automatic add_beat(logic [1:0] mode, logic [7:0] slave, logic [15:0] regnum,
                            logic [7:0] rx);
        beat_t b;
        b.mode   = mode;
        b.slave  = slave;
        b.regnum = regnum;
        b.rx     = rx;
        feed.push_back(b);
        n_queued++;
    endtask

    task automatic add_start(logic [7:0] slave, logic [15:0] regnum);
        add_beat(MODE_START, slave, regnum, 8'($urandom));
    endtask

    task automatic add_rx(logic [7:0] rx);
        add_beat(MODE_BYTE, 8'($urandom), 16'($urandom), rx);
    endtask

    task automatic add_tick();
        add_beat(MODE_TICK, 8'($urandom), 16'($urandom), 8'($urandom));
    endtask

    task automatic fill_response(output logic [7:0] rsp [7], input logic [7:0] func,
                                 input logic [15:0] value);
        logic [15:0] c;
        rsp[0] = 8'($urandom);
        rsp[1] = func;
        rsp[2] = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'd2;
        rsp[3] = value[15:8];
        rsp[4] = value[7:0];
        c = CRC_INIT;
        for (int i = 0; i < 5; i++) c = crc16_step(c, rsp[i]);
        rsp[5] = c[7:0];
        rsp[6] = c[15:8];
    endtask

    // Send response bytes, sprinkling ticks that stay inside the budget
    task automatic add_response(input logic [7:0] rsp [7], input int unsigned upto,
                                input int unsigned max_ticks);
        for (int i = 0; i < upto; i++) begin
            if (max_ticks != 0 && $urandom_range(0, 2) == 0)
                repeat ($urandom_range(1, max_ticks)) add_tick();
            add_rx(rsp[i]);
        end
    endtask

    task automatic add_random_txn();
        logic [7:0]  rsp [7];
        logic [7:0]  func;
        int unsigned pick, spacing, idx, bitn;
        pick = $urandom_range(0, 99);
        spacing = (tmo_ticks > 16'd1) ? ((tmo_ticks > 16'd4) ? 3 : tmo_ticks - 1) : 0;
        if (pick >= 90) begin
            // stray beats while nothing is outstanding
            repeat ($urandom_range(1, 3)) add_beat(2'($urandom_range(1, 3)), 8'($urandom),
                                                   16'($urandom), 8'($urandom));
        end else begin
            add_start(8'($urandom), 16'($urandom));
            func = ($urandom_range(0, 3) == 0) ? (8'($urandom) & 8'h7F) : FC_READ_HOLDING;
            if (pick >= 45 && pick < 60) func[EXC_BIT_POS] = 1'b1;
            fill_response(rsp, func, 16'($urandom));
            if ((pick >= 60 && pick < 75) || (func[EXC_BIT_POS] && $urandom_range(0, 1))) begin
                idx  = $urandom_range(0, 6);
                bitn = $urandom_range(0, 7);
                rsp[idx][bitn] = ~rsp[idx][bitn];
            end
            // a second start or a reserved mode mid-transaction must be dropped
            if ($urandom_range(0, 7) == 0)
                add_beat($urandom_range(0, 1) ? MODE_START : MODE_IGNORED, 8'($urandom),
                         16'($urandom), 8'($urandom));
            if (pick >= 75 && tmo_ticks <= 16'd40) begin
                add_response(rsp, $urandom_range(0, 6), spacing);
                repeat ((tmo_ticks == 16'd0) ? 1 : tmo_ticks) add_tick();
                repeat ($urandom_range(0, 2)) add_tick();
            end else begin
                add_response(rsp, 7, spacing);
            end
        end
    endtask

    task automatic settle();
        while (feed.size() != 0 || s_taken != s_offered || replies_due.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_timeout(logic [15:0] v);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        tmo_ticks = v;
    endtask

    initial begin
        logic [7:0]  rsp [7];
        logic [15:0] plan_tmo [6];
        plan_tmo = '{16'd65535, 16'd1, 16'd3, 16'd17, 16'd250, 16'd5};
        plan_tmo[5] = 16'($urandom_range(2, 40));

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: idle noise, field extremes, busy start, exception over bad CRC
        add_beat(MODE_BYTE, 8'h00, 16'h0000, 8'hFF);
        add_tick();
        add_beat(MODE_IGNORED, 8'hFF, 16'hFFFF, 8'hFF);
        add_start(8'hFF, 16'hFFFF);
        add_beat(MODE_START, 8'h00, 16'h0000, 8'h00);
        add_beat(MODE_IGNORED, 8'h00, 16'h0000, 8'h00);
        add_tick();
        fill_response(rsp, FC_READ_HOLDING, 16'h8000);
        add_response(rsp, 7, 0);
        add_start(8'h00, 16'h0000);
        fill_response(rsp, FC_READ_HOLDING | 8'h80, 16'h7FFF);
        rsp[6] = ~rsp[6];
        add_response(rsp, 7, 0);
        settle();

        // Zero budget acts as one tick
        write_timeout(16'd0);
        add_start(8'h5A, 16'h1234);
        add_tick();
        settle();

        foreach (plan_tmo[p]) begin
            write_timeout(plan_tmo[p]);
            calm = (p == 5);
            while (n_queued < 26 + PHASE_BEATS * (p + 1)) add_random_txn();
            hold_req = (p == 0);
            settle();
        end

        $display("%0d beats in, %0d frames out, %0d beats dropped; %0d result beats checked",
                 n_queued, n_frames, n_ignored, n_results);
        $display("completions ok/timeout/exception/crc: %0d/%0d/%0d/%0d over budgets 0..65535",
                 outcome_seen[STAT_OK], outcome_seen[STAT_TIMEOUT],
                 outcome_seen[STAT_EXCEPTION], outcome_seen[STAT_CRC_ERR]);
        if (replies_due.size() != 0) note_error($sformatf("%0d results never arrived",
                                                          replies_due.size()));
        if (n_errors == 0) begin
            $display("modbus_rtu_read_holding_register regression: pass");
        end else begin
            $display("%0d mismatches", n_errors);
            $display("modbus_rtu_read_holding_register regression: fail");
        end
        $finish;
    end

endmodule

/* modbus_rtu_read_holding_register.f */
+incdir+hdl
hdl/mbrtu_pkg.sv
hdl/mbrtu_front.sv
hdl/mbrtu_queue.sv
hdl/mbrtu_back.sv
hdl/modbus_rtu_read_holding_register.sv
tb/sv/modbus_rtu_read_holding_register_tb.sv
